>>> sv/assert_macros.svh
// Assertion macros shared by the generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define PCG_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pcg32 generator assertion failed");
// A condition that must never be seen outside reset.
`define PCG_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("pcg32 generator forbidden condition seen");
`else
`define PCG_ASSERT(label, prop)
`define PCG_NEVER(label, expr)
`endif

`endif

>>> sv/pcg_pkg.sv
// Shared types, constants and codes of the PCG32 generator.
package pcg_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned OUT_W  = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned STEP_W = 2;

  localparam logic [WORD_W-1:0] MULT_RESET = 64'd6364136223846793005;
  localparam logic [WORD_W-1:0] INC_RESET  = 64'd1442695040888963407;

  // Command kinds carried on the input channel.
  localparam logic [KIND_W-1:0] KIND_DRAW = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SKIP = 2'd2;

  // Register index, taken from address bit 3.
  localparam logic REG_MULT = 1'b0;
  localparam logic REG_INC  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAW,
    ST_SEED,
    ST_PUSH,
    ST_BIT,
    ST_AM,
    ST_AP,
    ST_CP,
    ST_CM,
    ST_FIN
  } seq_state_t;

  // Request to the shared multiply-add unit: result = a * b + c (mod 2^64).
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
  } mac_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] result;
  } mac_rsp_t;

endpackage

>>> sv/pcg_if.sv
// Valid/ready channel interfaces for generator commands and random words.
interface pcg_cmd_if import pcg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [WORD_W-1:0] operand_value;

  modport source (output valid, output kind, output operand_value, input ready);
  modport sink (input valid, input kind, input operand_value, output ready);
endinterface

interface pcg_word_if import pcg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

>>> sv/pcg_mac.sv
// Shared 64-bit multiply-add unit built on one 32x32 multiplier used in four steps.
module pcg_mac import pcg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mac_req_t req,
  output mac_rsp_t rsp
);

  localparam logic [STEP_W-1:0] STEP_LOLO = 2'd0;
  localparam logic [STEP_W-1:0] STEP_LOHI = 2'd1;
  localparam logic [STEP_W-1:0] STEP_HILO = 2'd2;
  localparam logic [STEP_W-1:0] STEP_LAST = 2'd3;

  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] prod;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [HALF_W-1:0] op_x;
  logic [HALF_W-1:0] op_y;
  logic [WORD_W-1:0] mul;

  // Only the low 64 bits of the product matter, so the high-by-high term is skipped.
  assign op_x = (step == STEP_HILO) ? a[WORD_W-1:HALF_W] : a[HALF_W-1:0];
  assign op_y = (step == STEP_LOHI) ? b[WORD_W-1:HALF_W] : b[HALF_W-1:0];
  assign mul  = {{HALF_W{1'b0}}, op_x} * {{HALF_W{1'b0}}, op_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_LOLO;
      done <= 1'b0;
    end else begin
      done <= busy && (step == STEP_LAST);
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_LOLO;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a   <= req.a;
      b   <= req.b;
      acc <= req.c;
    end else if (busy) begin
      if (step != STEP_LOLO) begin
        acc <= acc + prod;
      end
      if (step == STEP_LOLO) begin
        prod <= mul;
      end else begin
        prod <= {mul[HALF_W-1:0], {HALF_W{1'b0}}};
      end
    end
  end

  assign rsp = '{busy: busy, done: done, result: acc};

endmodule

>>> sv/pcg32_generator_skip_ahead.sv
// PCG32 XSH-RR generator with seeding and skip-ahead, top level.
//
//   channel  direction  handshake            payload
//   cmd      in         cmd.valid/cmd.ready  kind, operand_value
//   rnd      out        rnd.valid/rnd.ready  random_word
//   apb      in         psel/penable/pwrite  paddr, pwdata -> prdata, pready
//
// Every multiplication goes through one shared multiply-add unit; each
// operation is an issue, four multiplier steps and a result. A draw is one
// operation and a hand-off, a seed one operation. A skip ahead by delta runs
// four operations for each set bit and two for each clear bit of delta up to
// its highest set bit, then a final one. Reset is synchronous; it loads the
// default multiplier and increment and clears the state. A waiting word in
// the output register does not stop new commands; only the hand-off of a new
// word waits for the register to free, so a draw lasts longer while the
// receiver stalls.
`include "assert_macros.svh"

module pcg32_generator_skip_ahead import pcg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  pcg_cmd_if.sink           cmd,
  pcg_word_if.source        rnd,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned XS_SHIFT  = 18;
  localparam int unsigned OUT_SHIFT = 27;
  localparam int unsigned ROT_LSB   = 59;
  localparam int unsigned ROT_W     = WORD_W - ROT_LSB;

  // XSH-RR output permutation of a state word.
  function automatic logic [OUT_W-1:0] permute(input logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] mixed;
    logic [OUT_W-1:0]  xs;
    logic [ROT_W-1:0]  rot;
    logic [2*OUT_W-1:0] twice;
    mixed = ((s >> XS_SHIFT) ^ s) >> OUT_SHIFT;
    xs    = mixed[OUT_W-1:0];
    rot   = s[WORD_W-1:ROT_LSB];
    twice = {xs, xs} >> rot;
    return twice[OUT_W-1:0];
  endfunction

  logic [WORD_W-1:0] lcg_multiplier;
  logic [WORD_W-1:0] lcg_increment;
  logic [WORD_W-1:0] gen_state;

  // Skip-ahead accumulators: the jump so far is x -> am * x + ap, and
  // cm, cp describe the jump of 2^k steps for the current bit k.
  logic [WORD_W-1:0] am;
  logic [WORD_W-1:0] ap;
  logic [WORD_W-1:0] cm;
  logic [WORD_W-1:0] cp;
  logic [WORD_W-1:0] delta;
  logic [WORD_W-1:0] opnd;
  logic [OUT_W-1:0]  word_hold;

  logic              out_valid;
  logic [OUT_W-1:0]  out_word;

  seq_state_t st;
  seq_state_t st_next;
  logic       issued;
  logic       issued_next;

  mac_req_t mreq;
  mac_rsp_t mrsp;

  logic cmd_acc;
  logic cfg_wr;
  logic out_load;

  pcg_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // Configuration port. Address bit 3 selects the register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == REG_INC) ? lcg_increment : lcg_multiplier;

  assign cmd.ready = (st == ST_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign out_load  = (st == ST_PUSH) && (!out_valid || rnd.ready);

  assign rnd.valid       = out_valid;
  assign rnd.random_word = out_word;

  // Operands for the multiply-add unit in each arithmetic state.
  always_comb begin
    mreq = '{start: 1'b0, a: '0, b: '0, c: '0};
    unique case (st)
      ST_DRAW: begin
        mreq.a = gen_state;
        mreq.b = lcg_multiplier;
        mreq.c = lcg_increment;
      end
      ST_SEED: begin
        mreq.a = opnd;
        mreq.b = lcg_multiplier;
        mreq.c = lcg_increment;
      end
      ST_AM: begin
        mreq.a = am;
        mreq.b = cm;
      end
      ST_AP: begin
        mreq.a = ap;
        mreq.b = cm;
        mreq.c = cp;
      end
      ST_CP: begin
        mreq.a = cm + 64'd1;
        mreq.b = cp;
      end
      ST_CM: begin
        mreq.a = cm;
        mreq.b = cm;
      end
      ST_FIN: begin
        mreq.a = am;
        mreq.b = gen_state;
        mreq.c = ap;
      end
      default: begin
      end
    endcase
    mreq.start = !issued && (st == ST_DRAW || st == ST_SEED || st == ST_AM ||
                             st == ST_AP || st == ST_CP || st == ST_CM ||
                             st == ST_FIN);
  end

  // Sequencer: next state.
  always_comb begin
    st_next     = st;
    issued_next = issued;
    unique case (st)
      ST_IDLE: begin
        if (cmd.valid) begin
          unique case (cmd.kind)
            KIND_DRAW: st_next = ST_DRAW;
            KIND_SEED: st_next = ST_SEED;
            KIND_SKIP: st_next = ST_BIT;
            default:   st_next = ST_IDLE;
          endcase
        end
      end
      ST_PUSH: begin
        if (out_load) begin
          st_next = ST_IDLE;
        end
      end
      ST_BIT: begin
        if (delta == '0) begin
          st_next = ST_FIN;
        end else if (delta[0]) begin
          st_next = ST_AM;
        end else begin
          st_next = ST_CP;
        end
      end
      ST_DRAW, ST_SEED, ST_AM, ST_AP, ST_CP, ST_CM, ST_FIN: begin
        if (mreq.start) begin
          issued_next = 1'b1;
        end
        if (mrsp.done) begin
          issued_next = 1'b0;
          unique case (st)
            ST_DRAW: st_next = ST_PUSH;
            ST_AM:   st_next = ST_AP;
            ST_AP:   st_next = ST_CP;
            ST_CP:   st_next = ST_CM;
            ST_CM:   st_next = ST_BIT;
            default: st_next = ST_IDLE;
          endcase
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= ST_IDLE;
      issued         <= 1'b0;
      out_valid      <= 1'b0;
      lcg_multiplier <= MULT_RESET;
      lcg_increment  <= INC_RESET;
      gen_state      <= '0;
    end else begin
      st     <= st_next;
      issued <= issued_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rnd.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[3] == REG_INC) begin
          lcg_increment <= pwdata;
        end else begin
          lcg_multiplier <= pwdata;
        end
      end
      if (mrsp.done && (st == ST_DRAW || st == ST_SEED || st == ST_FIN)) begin
        gen_state <= mrsp.result;
      end
    end
  end

  // Working registers of the draw, seed and skip sequences.
  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      case (cmd.kind)
        KIND_DRAW: word_hold <= permute(gen_state);
        KIND_SEED: opnd <= lcg_increment + cmd.operand_value;
        KIND_SKIP: begin
          delta <= cmd.operand_value;
          am    <= 64'd1;
          ap    <= '0;
          cm    <= lcg_multiplier;
          cp    <= lcg_increment;
        end
        default: begin
        end
      endcase
    end
    if (mrsp.done) begin
      case (st)
        ST_AM: am <= mrsp.result;
        ST_AP: ap <= mrsp.result;
        ST_CP: cp <= mrsp.result;
        ST_CM: begin
          cm    <= mrsp.result;
          delta <= delta >> 1;
        end
        default: begin
        end
      endcase
    end
    if (out_load) begin
      out_word <= word_hold;
    end
  end

  // The shared unit is never restarted while it still works.
  `PCG_NEVER(a_mac_restart, mreq.start && mrsp.busy)
  // A result only comes back for an operation that the sequencer issued.
  `PCG_ASSERT(a_done_issued, mrsp.done |-> issued)
  // New commands are only taken while the shared unit is free.
  `PCG_ASSERT(a_ready_unit_free, cmd.ready |-> !mrsp.busy && !issued)
  // A word handed to the output register is the one permuted at acceptance.
  `PCG_ASSERT(a_push_word, out_load |=> out_valid && out_word == $past(word_hold))

endmodule
